>>> rtl/core/ps2kd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ps2kd_pkg;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CHAR    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_E0    = 2'd1,
    PH_E1    = 2'd2,
    PH_E1_B1 = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] key_number;
    logic [6:0] char_code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

  localparam logic [7:0] SC_PREFIX_E0  = 8'hE0;
  localparam logic [7:0] SC_PREFIX_E1  = 8'hE1;
  localparam logic [7:0] SC_LSHIFT_DN  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_DN  = 8'h36;
  localparam logic [7:0] SC_CTRL_DN    = 8'h1D;
  localparam logic [7:0] SC_ALT_DN     = 8'h38;
  localparam logic [7:0] SC_CAPS_DN    = 8'h3A;
  localparam logic [7:0] SC_LSHIFT_UP  = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_UP  = 8'hB6;
  localparam logic [7:0] SC_CTRL_UP    = 8'h9D;
  localparam logic [7:0] SC_ALT_UP     = 8'hB8;
  localparam logic [7:0] SC_PRINT_LIM  = 8'h3A;
  localparam logic [6:0] SC_PAUSE_HI   = 7'h1D;
  localparam logic [6:0] SC_PAUSE_LO   = 7'h45;
  localparam logic [7:0] KEY_PAUSE     = 8'd197;

  function automatic logic [6:0] lower_char(input logic [5:0] idx);
    logic [6:0] c;
    case (idx)
      6'd2: c = 7'h31;   6'd3: c = 7'h32;   6'd4: c = 7'h33;   6'd5: c = 7'h34;
      6'd6: c = 7'h35;   6'd7: c = 7'h36;   6'd8: c = 7'h37;   6'd9: c = 7'h38;
      6'd10: c = 7'h39;  6'd11: c = 7'h30;  6'd12: c = 7'h2D;  6'd13: c = 7'h3D;
      6'd16: c = 7'h71;  6'd17: c = 7'h77;  6'd18: c = 7'h65;  6'd19: c = 7'h72;
      6'd20: c = 7'h74;  6'd21: c = 7'h79;  6'd22: c = 7'h75;  6'd23: c = 7'h69;
      6'd24: c = 7'h6F;  6'd25: c = 7'h70;  6'd26: c = 7'h5B;  6'd27: c = 7'h5D;
      6'd30: c = 7'h61;  6'd31: c = 7'h73;  6'd32: c = 7'h64;  6'd33: c = 7'h66;
      6'd34: c = 7'h67;  6'd35: c = 7'h68;  6'd36: c = 7'h6A;  6'd37: c = 7'h6B;
      6'd38: c = 7'h6C;  6'd39: c = 7'h3B;  6'd40: c = 7'h27;  6'd41: c = 7'h60;
      6'd43: c = 7'h5C;  6'd44: c = 7'h7A;  6'd45: c = 7'h78;  6'd46: c = 7'h63;
      6'd47: c = 7'h76;  6'd48: c = 7'h62;  6'd49: c = 7'h6E;  6'd50: c = 7'h6D;
      6'd51: c = 7'h2C;  6'd52: c = 7'h2E;  6'd53: c = 7'h2F;  6'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] upper_char(input logic [5:0] idx);
    logic [6:0] c;
    case (idx)
      6'd2: c = 7'h21;   6'd3: c = 7'h40;   6'd4: c = 7'h23;   6'd5: c = 7'h24;
      6'd6: c = 7'h25;   6'd7: c = 7'h5E;   6'd8: c = 7'h26;   6'd9: c = 7'h2A;
      6'd10: c = 7'h28;  6'd11: c = 7'h29;  6'd12: c = 7'h5F;  6'd13: c = 7'h2B;
      6'd16: c = 7'h51;  6'd17: c = 7'h57;  6'd18: c = 7'h45;  6'd19: c = 7'h52;
      6'd20: c = 7'h54;  6'd21: c = 7'h59;  6'd22: c = 7'h55;  6'd23: c = 7'h49;
      6'd24: c = 7'h4F;  6'd25: c = 7'h50;  6'd26: c = 7'h7B;  6'd27: c = 7'h7D;
      6'd30: c = 7'h41;  6'd31: c = 7'h53;  6'd32: c = 7'h44;  6'd33: c = 7'h46;
      6'd34: c = 7'h47;  6'd35: c = 7'h48;  6'd36: c = 7'h4A;  6'd37: c = 7'h4B;
      6'd38: c = 7'h4C;  6'd39: c = 7'h3A;  6'd40: c = 7'h22;  6'd41: c = 7'h7E;
      6'd43: c = 7'h7C;  6'd44: c = 7'h5A;  6'd45: c = 7'h58;  6'd46: c = 7'h43;
      6'd47: c = 7'h56;  6'd48: c = 7'h42;  6'd49: c = 7'h4E;  6'd50: c = 7'h4D;
      6'd51: c = 7'h3C;  6'd52: c = 7'h3E;  6'd53: c = 7'h3F;  6'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ps2kd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2kd_decode (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic [7:0]          scan_byte,
  output ps2kd_pkg::dec_out_t      dec_out
);
  import ps2kd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic [2:0] mods_r, mods_nxt;

  logic       emit;
  logic [7:0] key_num;
  logic [6:0] chr;
  kind_t      key_kind;
  res_t       key_res;
  res_t       chr_res;

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    emit      = 1'b0;
    key_num   = {1'b0, scan_byte[6:0]};
    case (phase_r)
      PH_NONE: begin
        if (scan_byte == SC_PREFIX_E0) begin
          phase_nxt = PH_E0;
        end else if (scan_byte == SC_PREFIX_E1) begin
          phase_nxt = PH_E1;
        end else begin
          emit = (scan_byte != 8'h00);
        end
      end
      PH_E0: begin
        phase_nxt = PH_NONE;
        emit      = 1'b1;
        key_num   = {1'b1, scan_byte[6:0]};
      end
      PH_E1: begin
        phase_nxt = PH_E1_B1;
        held_nxt  = scan_byte;
      end
      PH_E1_B1: begin
        phase_nxt = PH_NONE;
        emit      = 1'b1;
        if (held_r == SC_PREFIX_E0) begin
          key_num = {1'b1, scan_byte[6:0]};
        end else if (held_r[6:0] == SC_PAUSE_HI && scan_byte[6:0] == SC_PAUSE_LO) begin
          key_num = KEY_PAUSE;
        end
      end
      default: begin
        phase_nxt = PH_NONE;
      end
    endcase
  end

  always_comb begin
    mods_nxt = mods_r;
    if (emit) begin
      if (scan_byte == SC_LSHIFT_UP || scan_byte == SC_RSHIFT_UP) begin
        mods_nxt[0] = 1'b0;
      end else if (scan_byte == SC_CTRL_UP) begin
        mods_nxt[1] = 1'b0;
      end else if (scan_byte == SC_ALT_UP) begin
        mods_nxt[2] = 1'b0;
      end else if (scan_byte == SC_LSHIFT_DN || scan_byte == SC_RSHIFT_DN) begin
        mods_nxt[0] = 1'b1;
      end else if (scan_byte == SC_CTRL_DN) begin
        mods_nxt[1] = 1'b1;
      end else if (scan_byte == SC_ALT_DN) begin
        mods_nxt[2] = 1'b1;
      end else if (scan_byte == SC_CAPS_DN) begin
        mods_nxt[0] = ~mods_r[0];
      end
    end
  end

  // Modifier codes all land on empty table slots, so the old flags pick the table.
  always_comb begin
    chr = 7'h00;
    if (scan_byte < SC_PRINT_LIM) begin
      chr = mods_r[0] ? upper_char(scan_byte[5:0]) : lower_char(scan_byte[5:0]);
    end
  end

  assign key_kind = scan_byte[7] ? KIND_RELEASE : KIND_PRESS;

  always_comb begin
    key_res.kind       = key_kind;
    key_res.key_number = key_num;
    key_res.char_code  = 7'h00;
    key_res.last       = (chr == 7'h00);
    chr_res.kind       = KIND_CHAR;
    chr_res.key_number = 8'h00;
    chr_res.char_code  = chr;
    chr_res.last       = 1'b1;
    dec_out.r0         = key_res;
    dec_out.r1         = chr_res;
    if (!emit) begin
      dec_out.count = 2'd0;
    end else if (chr == 7'h00) begin
      dec_out.count = 2'd1;
    end else begin
      dec_out.count = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NONE;
      held_r  <= 8'h00;
      mods_r  <= 3'b000;
    end else if (adv) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      mods_r  <= mods_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ps2kd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2kd_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  ps2kd_pkg::dec_out_t      din,
  output logic                     space2,
  output logic                     dout_valid,
  input  wire logic                pop,
  output ps2kd_pkg::res_t          dout
);
  import ps2kd_pkg::*;

  res_t       mem [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] push_n;
  logic       do_pop;

  assign push_n     = push ? din.count : 2'd0;
  assign dout_valid = (count_r != 3'd0);
  assign do_pop     = pop && dout_valid;
  assign space2     = (count_r <= 3'd2);
  assign dout       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_n;
    rd_ptr_nxt = rd_ptr_r + {1'b0, do_pop};
    count_nxt  = count_r + {1'b0, push_n} - {2'b00, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= din.r0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_r + 2'd1] <= din.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ps2_set1_key_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall  in_scan_byte
// out_      output     out_valid/out_stall  out_event_kind, out_key_number,
//                                           out_char_code, out_last
//
// A byte is registered on acceptance and decoded from that register, once the
// queue has room for two words, into zero, one or two words that enter a
// four-word output queue. One byte is taken per cycle while the queue has room
// for two words; sustained output is one word per cycle while out_stall is low.
// Reset clears the prefix phase, held byte, modifier flags and the queue.

module ps2_set1_key_decoder_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_scan_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_event_kind,
  output logic [7:0]      out_key_number,
  output logic [6:0]      out_char_code,
  output logic            out_last
);
  import ps2kd_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       space2;
  logic       adv;
  dec_out_t   dec_out;
  res_t       head;

  assign adv      = s1_valid_r && space2;
  assign in_stall = s1_valid_r && !space2;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_scan_byte;
    end
  end

  ps2kd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .scan_byte (s1_byte_r),
    .dec_out   (dec_out)
  );

  ps2kd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (adv),
    .din        (dec_out),
    .space2     (space2),
    .dout_valid (out_valid),
    .pop        (!out_stall),
    .dout       (head)
  );

  assign out_event_kind = head.kind;
  assign out_key_number = head.key_number;
  assign out_char_code  = head.char_code;
  assign out_last       = head.last;

endmodule

`default_nettype wire

>>> verif/tb_ps2_set1_key_decoder_core.sv
`timescale 1ns / 1ps

import ps2kd_pkg::*;

class key_event_board;
  res_t       pending[$];
  phase_t     phase;
  logic [7:0] held;
  logic       shift_held;
  logic       ctrl_held;
  logic       alt_held;
  int         errors;
  string      lower_keys;
  string      upper_keys;

  function new();
    phase      = PH_NONE;
    held       = '0;
    shift_held = 1'b0;
    ctrl_held  = 1'b0;
    alt_held   = 1'b0;
    errors     = 0;
    lower_keys = "  1234567890-=  qwertyuiop[]  asdfghjkl;'` \\zxcvbnm,./    ";
    upper_keys = "  !@#$%^&*()_+  QWERTYUIOP{}  ASDFGHJKL:\"~ |ZXCVBNM<>?    ";
  endfunction

  function int waiting();
    return pending.size();
  endfunction

  // Applies the modifier effect of a low byte and returns its character, or zero.
  function logic [6:0] low_byte_char(input logic [7:0] lb);
    byte c;
    if (lb == SC_LSHIFT_UP || lb == SC_RSHIFT_UP) begin
      shift_held = 1'b0;
      return '0;
    end
    if (lb == SC_CTRL_UP) begin
      ctrl_held = 1'b0;
      return '0;
    end
    if (lb == SC_ALT_UP) begin
      alt_held = 1'b0;
      return '0;
    end
    if (lb == SC_LSHIFT_DN || lb == SC_RSHIFT_DN) begin
      shift_held = 1'b1;
      return '0;
    end
    if (lb == SC_CTRL_DN) begin
      ctrl_held = 1'b1;
      return '0;
    end
    if (lb == SC_ALT_DN) begin
      alt_held = 1'b1;
      return '0;
    end
    if (lb == SC_CAPS_DN) begin
      shift_held = !shift_held;
      return '0;
    end
    if (lb >= SC_PRINT_LIM) return '0;
    case (lb)
      8'h00, 8'h01, 8'h0E, 8'h0F, 8'h1C, 8'h1D, 8'h2A, 8'h36, 8'h37, 8'h38: return '0;
      default: ;
    endcase
    c = shift_held ? upper_keys[lb] : lower_keys[lb];
    return c[6:0];
  endfunction

  function void note_byte(input logic [7:0] b);
    logic [23:0] code;
    logic [7:0]  key;
    logic [6:0]  ch;
    res_t        w;
    case (phase)
      PH_NONE: begin
        if (b == SC_PREFIX_E0) begin
          phase = PH_E0;
          return;
        end
        if (b == SC_PREFIX_E1) begin
          phase = PH_E1;
          return;
        end
        code = {16'h0000, b};
      end
      PH_E0: begin
        code  = {8'h00, SC_PREFIX_E0, b};
        phase = PH_NONE;
      end
      PH_E1: begin
        held  = b;
        phase = PH_E1_B1;
        return;
      end
      default: begin
        code  = {SC_PREFIX_E1, held, b};
        phase = PH_NONE;
      end
    endcase
    if (code == '0) return;
    if (code[15:8] == SC_PREFIX_E0) begin
      key = {1'b1, b[6:0]};
    end else if (code[23:16] == SC_PREFIX_E1 && code[14:8] == SC_PAUSE_HI &&
                 code[6:0] == SC_PAUSE_LO) begin
      key = KEY_PAUSE;
    end else begin
      key = {1'b0, b[6:0]};
    end
    ch = low_byte_char(b);
    w.kind       = b[7] ? KIND_RELEASE : KIND_PRESS;
    w.key_number = key;
    w.char_code  = '0;
    w.last       = (ch == '0);
    pending.insert(pending.size(), w);
    if (ch != '0) begin
      w.kind       = KIND_CHAR;
      w.key_number = '0;
      w.char_code  = ch;
      w.last       = 1'b1;
      pending.insert(pending.size(), w);
    end
  endfunction

  function void check_word(input logic [1:0] kind, input logic [7:0] key,
                           input logic [6:0] ch, input logic last);
    res_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected word, kind %0d key %h char %h last %b",
               $time, kind, key, ch, last);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (kind !== want.kind) begin
      $display("%0t: event kind expected %0d, actual %0d", $time, want.kind, kind);
      errors++;
    end
    if (key !== want.key_number) begin
      $display("%0t: key number expected %h, actual %h", $time, want.key_number, key);
      errors++;
    end
    if (ch !== want.char_code) begin
      $display("%0t: char code expected %h, actual %h", $time, want.char_code, ch);
      errors++;
    end
    if (last !== want.last) begin
      $display("%0t: last flag expected %b, actual %b", $time, want.last, last);
      errors++;
    end
  endfunction
endclass

module tb_ps2_set1_key_decoder_core;
  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_scan_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_event_kind;
  logic [7:0] out_key_number;
  logic [6:0] out_char_code;
  logic       out_last;

  key_event_board board;
  int             bytes_sent;
  int             send_idle_pct;
  int             recv_idle_pct;

  ps2_set1_key_decoder_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_scan_byte   (in_scan_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .out_key_number (out_key_number),
    .out_char_code  (out_char_code),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  // Called at a falling edge; returns at the falling edge after the byte is taken.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_scan_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.waiting() != 0);
  endtask

  task automatic send_random_sequence();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_byte(8'($urandom_range(1, 8'h58)) | {$urandom_range(0, 1) == 1, 7'h00});
    end else if (pick < 60) begin
      case ($urandom_range(0, 8))
        0: send_byte(SC_LSHIFT_DN);
        1: send_byte(SC_RSHIFT_DN);
        2: send_byte(SC_CTRL_DN);
        3: send_byte(SC_ALT_DN);
        4: send_byte(SC_CAPS_DN);
        5: send_byte(SC_LSHIFT_UP);
        6: send_byte(SC_RSHIFT_UP);
        7: send_byte(SC_CTRL_UP);
        default: send_byte(SC_ALT_UP);
      endcase
    end else if (pick < 75) begin
      send_byte(SC_PREFIX_E0);
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 87) begin
      send_byte(SC_PREFIX_E1);
      if ($urandom_range(0, 1) == 1) begin
        send_byte({$urandom_range(0, 1) == 1, SC_PAUSE_HI});
        send_byte({$urandom_range(0, 1) == 1, SC_PAUSE_LO});
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
      end
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_word(out_event_kind, out_key_number, out_char_code, out_last);
    end
  end

  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < recv_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5000000;
    $display("FAIL ps2_set1_key_decoder_core");
    $finish;
  end

  initial begin
    logic [7:0] opening[$];
    board         = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_scan_byte  = '0;
    bytes_sent    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 20;
    // Plain and extended zero codes, plain key, shift and caps lock toggling, the
    // other modifiers, table edges, prefix bytes used as data, and pause.
    opening = '{8'h00, 8'hE0, 8'h00, 8'h01, 8'h1E, 8'h2A, 8'h1E, 8'h02, 8'hAA,
                8'h3A, 8'h10, 8'h3A, 8'h1D, 8'h9D, 8'h38, 8'hB8, 8'h36, 8'h2B,
                8'h39, 8'hB6, 8'h58, 8'h59, 8'hFF, 8'h7F, 8'h80, 8'hE0, 8'h1C,
                8'hE0, 8'h9C, 8'hE0, 8'hE0, 8'hE0, 8'hE1, 8'hE1, 8'h1D, 8'h45,
                8'hE1, 8'h9D, 8'hC5, 8'hE1, 8'hE0, 8'hE1, 8'hE1, 8'h00, 8'h00,
                8'hE0, 8'h2A, 8'h35, 8'hE0, 8'hAA};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    foreach (opening[i]) send_byte(opening[i]);
    drain_results();
    while (bytes_sent < 1050) begin
      if (bytes_sent < 450) begin
        send_idle_pct = 25;
        recv_idle_pct = 25;
      end else if (bytes_sent < 650) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (bytes_sent < 950) begin
        send_idle_pct = 10;
        recv_idle_pct = 40;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random_sequence();
      if (bytes_sent >= 700 && bytes_sent < 704) drain_results();
    end
    drain_results();
    repeat (10) @(negedge clk);
    if (board.errors == 0 && board.waiting() == 0) begin
      $display("PASS ps2_set1_key_decoder_core");
    end else begin
      $display("FAIL ps2_set1_key_decoder_core");
    end
    $finish;
  end
endmodule
